// ===== src/nrp_pkg.sv =====
// Package for the note record parser: character codes, default sizes,
// the note letter decoder and the half-period table.
// No dependencies.
package nrp_pkg;

  // Default sizes for the top-level parameters
  localparam int NAME_CHARS_DEF    = 3;
  localparam int DURATION_BITS_DEF = 16;

  // Fixed field widths of a result word
  localparam int NOTE_W   = 8;
  localparam int DAC_W    = 8;
  localparam int DUR_W    = 16;
  localparam int HALF_W   = 10;
  localparam int TDATA_W  = 48;
  localparam int TUSER_W  = 2;
  localparam int PERIOD_W = 16;
  localparam int FRAC_BITS = 6;

  // Character codes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SHARP = 8'h23;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LO_O  = 8'h6F;
  localparam logic [7:0] CHAR_LO_F  = 8'h66;

  // Offset added to the note number for the DAC code
  localparam logic [7:0] DAC_OFFSET = 8'd127;

  // Semitone of a note letter; bit 4 set when the letter is A to G
  function automatic logic [4:0] semitone_of(input logic [7:0] c);
    logic [4:0] r;
    unique case (c)
      8'h43:   r = {1'b1, 4'd0};   // C
      8'h44:   r = {1'b1, 4'd2};   // D
      8'h45:   r = {1'b1, 4'd4};   // E
      8'h46:   r = {1'b1, 4'd5};   // F
      8'h47:   r = {1'b1, 4'd7};   // G
      8'h41:   r = {1'b1, 4'd9};   // A
      8'h42:   r = {1'b1, 4'd11};  // B
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // 64 * 10000 / base frequency of octave zero, rounded, C to B
  function automatic logic [PERIOD_W-1:0] period_of(input logic [3:0] s);
    logic [PERIOD_W-1:0] r;
    unique case (s)
      4'd0:    r = 16'd39144;
      4'd1:    r = 16'd36952;
      4'd2:    r = 16'd34877;
      4'd3:    r = 16'd32905;
      4'd4:    r = 16'd31068;
      4'd5:    r = 16'd29317;
      4'd6:    r = 16'd27682;
      4'd7:    r = 16'd26122;
      4'd8:    r = 16'd24653;
      4'd9:    r = 16'd23273;
      4'd10:   r = 16'd21963;
      4'd11:   r = 16'd20732;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/note_record_parser_unit.sv =====
// Note record parser: collects a note name line and a duration line from a
// byte stream and emits one decoded note record per two-line record.
// Depends on nrp_pkg.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+---------------------------------------
//  s_      | in  | s_tvalid/tready  | tdata[7:0] rx_byte
//  m_      | out | m_tvalid/tready  | tdata: note, dac, duration, half period
//          |     |                  | tuser: is_rest, bad_note
//
// One byte is taken in every cycle but for a stalled closing line feed. The
// parse state advances on the byte itself; the line feed that closes a record
// is decoded in the same cycle and lands in the output register in the next.
// Reset (rst, synchronous) clears the parse state and empties the output.
// While a result waits in the output register, bytes that do not close a
// record are still taken; only the closing line feed waits for the slot.
module note_record_parser_unit #(
  parameter int NAME_CHARS    = nrp_pkg::NAME_CHARS_DEF,
  parameter int DURATION_BITS = nrp_pkg::DURATION_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] note_number, [15:8] dac_code, [31:16] duration,
  // [41:32] half_period, [47:42] zero
  output logic [nrp_pkg::TDATA_W-1:0]  m_tdata,
  output logic [nrp_pkg::TUSER_W-1:0]  m_tuser    // [0] is_rest, [1] bad_note
);

  localparam int LEN_W = $clog2(NAME_CHARS + 1);
  localparam int IDX_W = $clog2(NAME_CHARS);

  // Parse state
  logic                     in_duration_line;
  logic [7:0]               name_chars [NAME_CHARS];
  logic [LEN_W-1:0]         name_length;
  logic [DURATION_BITS-1:0] duration_acc;
  logic [DURATION_BITS-1:0] duration_acc_next;

  logic accept;
  logic is_cr;
  logic is_lf;
  logic record_end;

  // Decode of the stored record
  logic                          rest;
  logic                          bad;
  logic [4:0]                    semi;
  logic                          sharp;
  logic [7:0]                    oct_char;
  logic                          oct_ok;
  logic [3:0]                    oct;
  logic [3:0]                    oct_inc;
  logic [3:0]                    semi_s;
  logic [3:0]                    per_semi;
  logic [3:0]                    per_oct;
  logic [4:0]                    shift;
  logic [nrp_pkg::PERIOD_W:0]    per_t;
  logic [nrp_pkg::PERIOD_W:0]    per_mask;
  logic [nrp_pkg::PERIOD_W:0]    per_ceil;
  logic [nrp_pkg::NOTE_W-1:0]    num;
  logic [nrp_pkg::NOTE_W-1:0]    num_o;
  logic [nrp_pkg::DAC_W-1:0]     dac_o;
  logic [nrp_pkg::HALF_W-1:0]    half_o;
  logic [31:0]                   dur_ext;

  // Byte classes and handshake
  assign is_cr      = (s_tdata == nrp_pkg::CHAR_CR);
  assign is_lf      = (s_tdata == nrp_pkg::CHAR_LF);
  assign record_end = in_duration_line && is_lf;
  assign s_tready   = !record_end || !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;

  // Duration digit: acc * 10 + byte - '0', wrapping
  assign duration_acc_next = (duration_acc << 3) + (duration_acc << 1)
                             + DURATION_BITS'(s_tdata)
                             - DURATION_BITS'(nrp_pkg::CHAR_ZERO);

  // Advance the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_duration_line <= 1'b0;
      name_length      <= '0;
      duration_acc     <= '0;
      for (int i = 0; i < NAME_CHARS; i++) name_chars[i] <= '0;
    end else if (accept && !is_cr) begin
      if (!in_duration_line) begin
        if (is_lf) begin
          in_duration_line <= 1'b1;
        end else if (s_tdata != nrp_pkg::CHAR_NUL &&
                     name_length < LEN_W'(NAME_CHARS)) begin
          name_chars[name_length[IDX_W-1:0]] <= s_tdata;
          name_length <= name_length + LEN_W'(1);
        end
      end else if (is_lf) begin
        in_duration_line <= 1'b0;
        name_length      <= '0;
        duration_acc     <= '0;
        for (int i = 0; i < NAME_CHARS; i++) name_chars[i] <= '0;
      end else begin
        duration_acc <= duration_acc_next;
      end
    end
  end

  // Decode the note name; unused positions already read as zero
  always_comb begin
    rest = (name_length == LEN_W'(3)) &&
           (name_chars[0] == nrp_pkg::CHAR_LO_O) &&
           (name_chars[1] == nrp_pkg::CHAR_LO_F) &&
           (name_chars[2] == nrp_pkg::CHAR_LO_F);
    semi     = nrp_pkg::semitone_of(name_chars[0]);
    sharp    = (name_chars[1] == nrp_pkg::CHAR_SHARP);
    oct_char = sharp ? name_chars[2] : name_chars[1];
    oct_ok   = (oct_char >= nrp_pkg::CHAR_ZERO) && (oct_char <= nrp_pkg::CHAR_NINE);
    bad      = !rest && (!semi[4] || !oct_ok);
    oct      = oct_char[3:0];
    oct_inc  = oct + 4'd1;
    semi_s   = semi[3:0] + {3'b000, sharp};
    num      = 8'({oct_inc, 3'b000}) + 8'({oct_inc, 2'b00}) + 8'(semi_s);

    // B sharp wraps to C of the next octave for the period
    if (semi_s == 4'd12) begin
      per_semi = 4'd0;
      per_oct  = oct_inc;
    end else begin
      per_semi = semi_s;
      per_oct  = oct;
    end
    shift    = 5'(per_oct) + 5'(nrp_pkg::FRAC_BITS);
    per_t    = (nrp_pkg::PERIOD_W+1)'(nrp_pkg::period_of(per_semi));
    per_mask = ((nrp_pkg::PERIOD_W+1)'(1) << shift) - (nrp_pkg::PERIOD_W+1)'(1);
    // Round up: floor plus one when any shifted-out bit is set
    per_ceil = (per_t >> shift) + (nrp_pkg::PERIOD_W+1)'(|(per_t & per_mask));

    if (rest || bad) begin
      num_o  = '0;
      dac_o  = '0;
      half_o = '0;
    end else begin
      num_o  = num;
      dac_o  = num + nrp_pkg::DAC_OFFSET;
      half_o = per_ceil[nrp_pkg::HALF_W-1:0];
    end
    dur_ext = 32'(duration_acc);
  end

  // Output register: load on the closing line feed, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && record_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && record_end) begin
      m_tdata <= {6'b000000, half_o, dur_ext[nrp_pkg::DUR_W-1:0], dac_o, num_o};
      m_tuser <= {bad, rest};
    end
  end

  // Checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("rest and bad note flags both set");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (accept && record_end) |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  a_clear_after_record: assert property (@(posedge clk) disable iff (rst)
    (accept && record_end) |=> (!in_duration_line && name_length == '0 &&
                                duration_acc == '0))
    else $error("parse state not cleared after record");

  a_zero_on_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] || m_tuser[1])) |->
      (m_tdata[7:0] == 8'd0 && m_tdata[41:32] == 10'd0))
    else $error("note fields not zero for rest or bad note");

endmodule
